// ----- rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and helpers for the password line editor: event and
// character-class codes, configuration indexes and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam int LINE_DEPTH_DEF = 32;
	localparam int BYTE_W         = 8;
	localparam int FILL_W         = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;

	// reset values of the configuration registers
	localparam logic [23:0] END_CHARS_RST    = 24'd4;
	localparam logic [31:0] SIGNAL_CHARS_RST = 32'd438043414;
	localparam logic [31:0] EDIT_CHARS_RST   = 32'd353861401;
	localparam logic        ALT_WERASE_RST   = 1'b0;
	localparam logic        ECHO_ENABLE_RST  = 1'b1;

	// fixed characters
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NL         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_END_CHARS      = 3'd0,
		CFG_SIGNAL_CHARS   = 3'd1,
		CFG_EDIT_CHARS     = 3'd2,
		CFG_ALT_WORD_ERASE = 3'd3,
		CFG_ECHO_ENABLE    = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		EV_SPACE = 3'd0,
		EV_BELL  = 3'd1,
		EV_BS    = 3'd2,
		EV_INTR  = 3'd3,
		EV_QUIT  = 3'd4,
		EV_SUSP  = 3'd5,
		EV_BYTE  = 3'd6,
		EV_EMPTY = 3'd7
	} ev_t;

	typedef enum logic [3:0] {
		CL_END,
		CL_LNEXT,
		CL_INTR,
		CL_QUIT,
		CL_SUSP,
		CL_ERASE,
		CL_WERASE,
		CL_KILL,
		CL_NORMAL
	} cls_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_LAST,
		RD_NEXT,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [1:0] {
		TGT_CUR,
		TGT_DEC,
		TGT_ZERO
	} tgt_sel_t;

	typedef enum logic [1:0] {
		OUT_RES,
		OUT_BS,
		OUT_BYTE
	} out_src_t;

	typedef struct packed {
		logic     byte_ld;
		logic     wr_en;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     cnt_clr;
		logic     cnt_to_tgt;
		logic     lit_set;
		logic     lit_clr;
		logic     res_ld;
		ev_t      res_ev;
		logic     res_inc;
		logic     tgt_ld;
		tgt_sel_t tgt_sel;
		logic     scan_start;
		logic     scan_step;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     out_ld;
		out_src_t out_src;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic lit;
		logic cnt_zero;
		logic full;
		logic echo;
		logic out_free;
		logic emit_last;
		logic scan_del;
		logic ptr_zero;
		logic bs_last;
	} sts_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			((b >= 8'h61) && (b <= 8'h7A)) || (b == CH_UNDERSCORE);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/password_line_editor.sv -----
// ----------------------------------------------------------------------------
// password_line_editor
// Hidden line editor for password entry: keeps typed bytes out of sight and
// reports echo, signal and line-completion results.
// ----------------------------------------------------------------------------
// Use: typed bytes enter on the in_ valid/ready channel, one beat per byte.
// Each byte gives zero or more result beats on the out_ channel; the last
// beat of a byte has last set. Registers are written on the cfg_ channel
// (index, data), which is always ready; write them only while idle.
// Ending a line reads the line store forwards and sends each byte. Word erase
// walks the single read port one entry a cycle backwards to find the word
// boundary; erase, word erase and kill then send one backspace per byte. With
// echo off no backspaces are sent and the count is set to the target at once.
// The output register lets a new byte be accepted while the last result of
// the previous one still waits. A stalled receiver holds the block in its
// emit loop; nothing is dropped.
// Reset clears the count, the literal-next flag and the registers to their
// defaults; the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module password_line_editor #(
	parameter int LINE_DEPTH = ple_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ple_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ple_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ple_pkg::BYTE_W-1:0]     typed_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [2:0]                          event_res,
	output logic [ple_pkg::BYTE_W-1:0]          data_byte,
	output logic [ple_pkg::FILL_W-1:0]          fill_count,
	output logic                                last
);

	ple_pkg::cmd_t cmd;
	ple_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ple_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.typed_byte (typed_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.event_res  (event_res),
		.data_byte  (data_byte),
		.fill_count (fill_count),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- rtl/ple_ram.sv -----
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/ple_dp.sv -----
// ----------------------------------------------------------------------------
// ple_dp
// Datapath: configuration registers, byte classifier, line store, count,
// literal-next flag, word-erase scanner and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_dp #(
	parameter int LINE_DEPTH = ple_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [ple_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ple_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [ple_pkg::BYTE_W-1:0]       typed_byte,
	input  wire ple_pkg::cmd_t                    cmd,
	output ple_pkg::sts_t                         sts,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic [2:0]                            event_res,
	output logic [ple_pkg::BYTE_W-1:0]            data_byte,
	output logic [ple_pkg::FILL_W-1:0]            fill_count,
	output logic                                  last
);

	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int FW = ple_pkg::FILL_W;

	typedef enum logic [2:0] {
		PH_WS,
		PH_NWS,
		PH_FIRST,
		PH_WORD,
		PH_PUNCT
	} phase_t;

	logic [23:0]   end_chars_q;
	logic [31:0]   signal_chars_q;
	logic [31:0]   edit_chars_q;
	logic          alt_q;
	logic          echo_q;
	logic [7:0]    byte_q;
	logic [CW-1:0] cnt_q;
	logic          lit_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] tgt_q;
	phase_t        phase_q;
	ple_pkg::ev_t  res_ev_q;
	logic [CW-1:0] res_cnt_q;

	logic          out_valid_q;
	ple_pkg::ev_t  out_ev_q;
	logic [7:0]    out_data_q;
	logic [FW-1:0] out_fill_q;
	logic          out_last_q;

	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	ple_pkg::cls_t cls;
	logic          is_end;
	logic          scan_del;
	phase_t        phase_nxt;
	logic          rd_ws;
	logic          rd_word;
	logic          out_free;
	logic          emit_last;
	logic          bs_last;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_chars_q    <= ple_pkg::END_CHARS_RST;
			signal_chars_q <= ple_pkg::SIGNAL_CHARS_RST;
			edit_chars_q   <= ple_pkg::EDIT_CHARS_RST;
			alt_q          <= ple_pkg::ALT_WERASE_RST;
			echo_q         <= ple_pkg::ECHO_ENABLE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ple_pkg::CFG_END_CHARS:      end_chars_q    <= cfg_data[23:0];
				ple_pkg::CFG_SIGNAL_CHARS:   signal_chars_q <= cfg_data;
				ple_pkg::CFG_EDIT_CHARS:     edit_chars_q   <= cfg_data;
				ple_pkg::CFG_ALT_WORD_ERASE: alt_q          <= cfg_data[0];
				ple_pkg::CFG_ECHO_ENABLE:    echo_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// classify the held byte, end characters win even under literal-next
	always_comb begin
		is_end = (byte_q == ple_pkg::CH_NL) || (byte_q == ple_pkg::CH_CR) ||
			(byte_q == ple_pkg::CH_NUL) || (byte_q == end_chars_q[7:0]) ||
			(byte_q == end_chars_q[15:8]) || (byte_q == end_chars_q[23:16]);
		if (is_end) begin
			cls = ple_pkg::CL_END;
		end else if (lit_q) begin
			cls = ple_pkg::CL_NORMAL;
		end else if (byte_q == signal_chars_q[7:0]) begin
			cls = ple_pkg::CL_LNEXT;
		end else if (byte_q == signal_chars_q[15:8]) begin
			cls = ple_pkg::CL_INTR;
		end else if (byte_q == signal_chars_q[23:16]) begin
			cls = ple_pkg::CL_QUIT;
		end else if (byte_q == signal_chars_q[31:24] || byte_q == edit_chars_q[7:0]) begin
			cls = ple_pkg::CL_SUSP;
		end else if (byte_q == edit_chars_q[15:8]) begin
			cls = ple_pkg::CL_ERASE;
		end else if (byte_q == edit_chars_q[23:16]) begin
			cls = ple_pkg::CL_WERASE;
		end else if (byte_q == edit_chars_q[31:24]) begin
			cls = ple_pkg::CL_KILL;
		end else begin
			cls = ple_pkg::CL_NORMAL;
		end
	end

	// line store read address
	always_comb begin
		case (cmd.rd_sel)
			ple_pkg::RD_FIRST: rd_addr = '0;
			ple_pkg::RD_LAST:  rd_addr = AW'(cnt_q - 1'b1);
			ple_pkg::RD_NEXT:  rd_addr = ptr_q + 1'b1;
			default:           rd_addr = ptr_q - 1'b1;
		endcase
	end

	ple_ram #(
		.WIDTH (ple_pkg::BYTE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (AW'(cnt_q)),
		.wr_data (byte_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// word-erase scan: decide whether the byte just read goes too
	always_comb begin
		rd_ws     = ple_pkg::is_ws(rd_data);
		rd_word   = ple_pkg::is_word(rd_data);
		scan_del  = 1'b0;
		phase_nxt = phase_q;
		case (phase_q)
			PH_WS: begin
				scan_del = 1'b1;
				if (!rd_ws) begin
					phase_nxt = alt_q ? PH_FIRST : PH_NWS;
				end
			end
			PH_NWS: scan_del = !rd_ws;
			PH_FIRST: begin
				if (rd_word) begin
					scan_del  = 1'b1;
					phase_nxt = PH_WORD;
				end else if (!rd_ws) begin
					scan_del  = 1'b1;
					phase_nxt = PH_PUNCT;
				end
			end
			PH_WORD:  scan_del = rd_word;
			default:  scan_del = !rd_word && !rd_ws;
		endcase
	end

	assign out_free  = !out_valid_q || out_ready;
	assign emit_last = (CW'(ptr_q) + 1'b1) == cnt_q;
	assign bs_last   = (cnt_q - 1'b1) == tgt_q;

	always_comb begin
		sts.cls       = cls;
		sts.lit       = lit_q;
		sts.cnt_zero  = cnt_q == '0;
		sts.full      = cnt_q == CW'(LINE_DEPTH);
		sts.echo      = echo_q;
		sts.out_free  = out_free;
		sts.emit_last = emit_last;
		sts.scan_del  = scan_del;
		sts.ptr_zero  = ptr_q == '0;
		sts.bs_last   = bs_last;
	end

	// count and literal-next flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lit_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (cmd.cnt_to_tgt) begin
				cnt_q <= tgt_q;
			end
			if (cmd.lit_set) begin
				lit_q <= 1'b1;
			end else if (cmd.lit_clr) begin
				lit_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.byte_ld) begin
			byte_q <= typed_byte;
		end
		if (cmd.rd_en) begin
			ptr_q <= rd_addr;
		end
		if (cmd.scan_start) begin
			phase_q <= PH_WS;
		end else if (cmd.scan_step && scan_del) begin
			phase_q <= phase_nxt;
		end
		if (cmd.tgt_ld) begin
			case (cmd.tgt_sel)
				ple_pkg::TGT_CUR: tgt_q <= cnt_q;
				ple_pkg::TGT_DEC: tgt_q <= cnt_q - 1'b1;
				default:          tgt_q <= '0;
			endcase
		end else if (cmd.scan_step && scan_del) begin
			tgt_q <= CW'(ptr_q);
		end
		if (cmd.res_ld) begin
			res_ev_q  <= cmd.res_ev;
			res_cnt_q <= cmd.res_inc ? cnt_q + 1'b1 : cnt_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			case (cmd.out_src)
				ple_pkg::OUT_RES: begin
					out_ev_q   <= res_ev_q;
					out_data_q <= '0;
					out_fill_q <= FW'(res_cnt_q);
					out_last_q <= 1'b1;
				end
				ple_pkg::OUT_BS: begin
					out_ev_q   <= ple_pkg::EV_BS;
					out_data_q <= '0;
					out_fill_q <= FW'(cnt_q - 1'b1);
					out_last_q <= bs_last;
				end
				default: begin
					out_ev_q   <= ple_pkg::EV_BYTE;
					out_data_q <= rd_data;
					out_fill_q <= FW'(cnt_q);
					out_last_q <= emit_last;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = out_ev_q;
	assign data_byte  = out_data_q;
	assign fill_count = out_fill_q;
	assign last       = out_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LINE_DEPTH))
		else $error("line count beyond depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (cnt_q < CW'(LINE_DEPTH)) && !cmd.cnt_dec && !cmd.cnt_clr)
		else $error("line store written with no room");

	a_bs_above_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> tgt_q < cnt_q)
		else $error("backspace below erase target");

	a_emit_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld && cmd.out_src == ple_pkg::OUT_BYTE) |-> CW'(ptr_q) < cnt_q)
		else $error("line byte emitted past the count");
`endif

endmodule

`default_nettype wire

// ----- rtl/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller: takes one typed byte, decides its action from the datapath
// status and sequences line emission, word-erase scan and backspaces.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ple_pkg::sts_t sts,
	output ple_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PUT,
		S_EMIT,
		S_SCAN,
		S_ERASE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.byte_ld = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				unique case (sts.cls) inside
					ple_pkg::CL_END: begin
						if (sts.lit) begin
							cmd.lit_clr = 1'b1;
							if (sts.echo) begin
								cmd.res_ld = 1'b1;
								cmd.res_ev = ple_pkg::EV_BELL;
								state_d    = S_PUT;
							end
						end else if (sts.cnt_zero) begin
							cmd.res_ld = 1'b1;
							cmd.res_ev = ple_pkg::EV_EMPTY;
							state_d    = S_PUT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = ple_pkg::RD_FIRST;
							state_d    = S_EMIT;
						end
					end
					ple_pkg::CL_LNEXT: cmd.lit_set = 1'b1;
					ple_pkg::CL_INTR, ple_pkg::CL_QUIT, ple_pkg::CL_SUSP: begin
						cmd.res_ld = 1'b1;
						cmd.res_ev = (sts.cls == ple_pkg::CL_INTR) ? ple_pkg::EV_INTR :
							(sts.cls == ple_pkg::CL_QUIT) ? ple_pkg::EV_QUIT : ple_pkg::EV_SUSP;
						state_d    = S_PUT;
					end
					ple_pkg::CL_ERASE, ple_pkg::CL_WERASE, ple_pkg::CL_KILL: begin
						if (sts.cnt_zero) begin
							if (sts.echo) begin
								cmd.res_ld = 1'b1;
								cmd.res_ev = ple_pkg::EV_BELL;
								state_d    = S_PUT;
							end
						end else if (sts.cls == ple_pkg::CL_WERASE) begin
							cmd.tgt_ld     = 1'b1;
							cmd.tgt_sel    = ple_pkg::TGT_CUR;
							cmd.scan_start = 1'b1;
							cmd.rd_en      = 1'b1;
							cmd.rd_sel     = ple_pkg::RD_LAST;
							state_d        = S_SCAN;
						end else begin
							cmd.tgt_ld  = 1'b1;
							cmd.tgt_sel = (sts.cls == ple_pkg::CL_KILL) ?
								ple_pkg::TGT_ZERO : ple_pkg::TGT_DEC;
							state_d     = S_ERASE;
						end
					end
					default: begin
						// ordinary byte: store it unless the line is full
						if (!sts.full) begin
							cmd.wr_en   = 1'b1;
							cmd.cnt_inc = 1'b1;
							cmd.lit_clr = 1'b1;
						end
						if (sts.echo) begin
							cmd.res_ld  = 1'b1;
							cmd.res_ev  = sts.full ? ple_pkg::EV_BELL : ple_pkg::EV_SPACE;
							cmd.res_inc = !sts.full;
							state_d     = S_PUT;
						end
					end
				endcase
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.out_src = ple_pkg::OUT_RES;
					state_d     = S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.out_src = ple_pkg::OUT_BYTE;
					if (sts.emit_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = ple_pkg::RD_NEXT;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_del && !sts.ptr_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ple_pkg::RD_PREV;
				end else begin
					state_d = S_ERASE;
				end
			end
			S_ERASE: begin
				if (!sts.echo) begin
					cmd.cnt_to_tgt = 1'b1;
					state_d        = S_IDLE;
				end else if (sts.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.out_src = ple_pkg::OUT_BS;
					cmd.cnt_dec = 1'b1;
					if (sts.bs_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= state_d == S_IDLE;
		end
	end

	assign in_ready = in_ready_q;

endmodule

`default_nettype wire
